@@ hdl/bbcd_pkg.sv @@
// Package: types, constants and codes for the buffer cache directory.
`default_nettype none
package bbcd_pkg;
  localparam int unsigned EntryCount  = 32;
  localparam int unsigned BucketCount = 16;
  localparam int unsigned IdxW        = $clog2(EntryCount);
  localparam int unsigned BktW        = (BucketCount > 1) ? $clog2(BucketCount) : 1;
  localparam int unsigned CntW        = IdxW + 1;
  localparam logic [7:0]  CountMax    = 8'hff;

  localparam logic [1:0] OpRead    = 2'd0;
  localparam logic [1:0] OpRelease = 2'd1;
  localparam logic [1:0] OpPin     = 2'd2;
  localparam logic [1:0] OpUnpin   = 2'd3;

  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StNoFree    = 2'd1;
  localparam logic [1:0] StUnderflow = 2'd2;
  localparam logic [1:0] StOverflow  = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  device;
    logic [30:0] block_number;
    logic [4:0]  entry_index;
    logic [31:0] now_tick;
  } req_t;

  typedef struct packed {
    logic [4:0] result_index;
    logic       need_disk_read;
    logic [1:0] status;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic scan_last;
  } sts_t;

  function automatic logic [BktW-1:0] bucket_of(input logic [30:0] blk);
    return BktW'(blk % BucketCount);
  endfunction
endpackage
`default_nettype wire

@@ hdl/bbcd_ctrl.sv @@
// Controller: sequences load, entry scan (reads only) and commit for each item.
`default_nettype none
module bbcd_ctrl import bbcd_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start_i,
  output logic busy_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts_i.is_read) state_d = S_COMMIT;
        else begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.scan_last) state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
endmodule
`default_nettype wire

@@ hdl/bbcd_datapath.sv @@
// Datapath: entry tables, scan for hit and oldest victims, entry update.
`default_nettype none
module bbcd_datapath import bbcd_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic done_o,
  output rsp_t rsp_o
);
  logic [EntryCount-1:0] in_use_q, valid_q;
  logic [7:0]  dev_q   [EntryCount];
  logic [30:0] blk_q   [EntryCount];
  logic [7:0]  cnt_q   [EntryCount];
  logic [31:0] rtime_q [EntryCount];

  req_t req_q;
  logic [IdxW-1:0] ptr_q;
  logic hit_q, bkt_f_q, all_f_q;
  logic [IdxW-1:0] hit_i_q, bkt_i_q, all_i_q;
  logic [31:0] bkt_t_q, all_t_q;

  logic cur_free, cur_hit, cur_bkt;
  assign cur_free = (cnt_q[ptr_q] == 8'd0);
  assign cur_hit = in_use_q[ptr_q] && dev_q[ptr_q] == req_q.device
                   && blk_q[ptr_q] == req_q.block_number;
  assign cur_bkt = in_use_q[ptr_q]
                   && bucket_of(blk_q[ptr_q]) == bucket_of(req_q.block_number);

  assign sts_o.is_read = (req_q.opcode == OpRead);
  assign sts_o.scan_last = (CntW'(ptr_q) == CntW'(EntryCount - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.scan_clr) begin
      ptr_q <= '0;
      hit_q <= 1'b0;
      bkt_f_q <= 1'b0;
      all_f_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      if (!sts_o.scan_last) ptr_q <= ptr_q + 1'b1;
      if (cur_hit && !hit_q) begin
        hit_q <= 1'b1;
        hit_i_q <= ptr_q;
      end
      if (cur_free && cur_bkt && (!bkt_f_q || rtime_q[ptr_q] < bkt_t_q)) begin
        bkt_f_q <= 1'b1;
        bkt_i_q <= ptr_q;
        bkt_t_q <= rtime_q[ptr_q];
      end
      if (cur_free && (!all_f_q || rtime_q[ptr_q] < all_t_q)) begin
        all_f_q <= 1'b1;
        all_i_q <= ptr_q;
        all_t_q <= rtime_q[ptr_q];
      end
    end
  end

  logic [IdxW-1:0] vic, ei;
  logic in_rng;
  assign vic = bkt_f_q ? bkt_i_q : all_i_q;
  assign ei = req_q.entry_index[IdxW-1:0];
  assign in_rng = (32'(req_q.entry_index) < EntryCount);

  rsp_t rsp_d;

  always_comb begin
    rsp_d = '{result_index: req_q.entry_index, need_disk_read: 1'b0, status: StOk};
    if (req_q.opcode == OpRead) begin
      if (hit_q) begin
        rsp_d.result_index = 5'(hit_i_q);
        if (cnt_q[hit_i_q] == CountMax) rsp_d.status = StOverflow;
        else rsp_d.need_disk_read = !valid_q[hit_i_q];
      end else if (bkt_f_q || all_f_q) begin
        rsp_d.result_index = 5'(vic);
        rsp_d.need_disk_read = 1'b1;
      end else begin
        rsp_d.result_index = '0;
        rsp_d.status = StNoFree;
      end
    end else if (in_rng) begin
      if (req_q.opcode == OpPin) begin
        if (cnt_q[ei] == CountMax) rsp_d.status = StOverflow;
      end else if (cnt_q[ei] == 8'd0) rsp_d.status = StUnderflow;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      valid_q <= '0;
      done_o <= 1'b0;
      rsp_o <= '0;
      for (int i = 0; i < EntryCount; i++) begin
        dev_q[i] <= '0;
        blk_q[i] <= '0;
        cnt_q[i] <= '0;
        rtime_q[i] <= '0;
      end
    end else begin
      done_o <= cmd_i.commit;
      if (cmd_i.commit) begin
        rsp_o <= rsp_d;
        if (req_q.opcode == OpRead) begin
          if (hit_q) begin
            if (cnt_q[hit_i_q] != CountMax) begin
              cnt_q[hit_i_q] <= cnt_q[hit_i_q] + 8'd1;
              valid_q[hit_i_q] <= 1'b1;
            end
          end else if (bkt_f_q || all_f_q) begin
            in_use_q[vic] <= 1'b1;
            valid_q[vic] <= 1'b1;
            dev_q[vic] <= req_q.device;
            blk_q[vic] <= req_q.block_number;
            cnt_q[vic] <= 8'd1;
          end
        end else if (in_rng) begin
          if (req_q.opcode == OpPin) begin
            if (cnt_q[ei] != CountMax) cnt_q[ei] <= cnt_q[ei] + 8'd1;
          end else if (cnt_q[ei] != 8'd0) begin
            cnt_q[ei] <= cnt_q[ei] - 8'd1;
            if (req_q.opcode == OpRelease && cnt_q[ei] == 8'd1)
              rtime_q[ei] <= req_q.now_tick;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ hdl/block_buffer_cache_directory.sv @@
// Top level: buffer cache directory with reference counts and LRU replacement.
//  channel  | ports                     | handshake
//  request  | start_i, req_i            | taken when start_i && !busy_o
//  response | done_o, rsp_o             | one-cycle strobe, no backpressure
// Read: load, then a scan of all 32 entries (one entry per cycle), then commit.
// Release/pin/unpin: load, then commit, with no entry scan. The entry scan sets the read rate.
// Reset clears all entry tables at once; no sweep. Results cannot stall.
`default_nettype none
module block_buffer_cache_directory import bbcd_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output rsp_t rsp_o
);
  cmd_t cmd;
  sts_t sts;

  bbcd_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .busy_o, .sts_i(sts), .cmd_o(cmd)
  );

  bbcd_datapath u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .sts_o(sts), .done_o, .rsp_o
  );

`ifndef SYNTHESIS
  a_done_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> done_o) else $error("missing result strobe");
  a_busy_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("item not taken");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.scan_step, cmd.commit})) else $error("cmd clash");
`endif
endmodule
`default_nettype wire
